>>> src/hermite_curve_sampler_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Hermite curve sampler
// Shared concurrent assertion forms, clocked and gated by the reset.
// ----------------------------------------------------------------------------
`ifndef HERMITE_CURVE_SAMPLER_ASSERT_SVH
`define HERMITE_CURVE_SAMPLER_ASSERT_SVH

// Property holds at every edge outside reset
`define HCS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Antecedent implies consequent on the same edge
`define HCS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> src/hcs_pkg.sv
// ----------------------------------------------------------------------------
// hcs_pkg
// Constants and types shared by the curve sampler modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hcs_pkg;

    localparam int HCS_MAX_POINTS = 64;
    localparam int HCS_PC_W       = 7;
    localparam logic [HCS_PC_W-1:0] HCS_PC_RESET = 7'd16;
    localparam int HCS_Q_DEPTH    = 2;

    // three Q16.16 coordinates, index 0 is x
    typedef logic [2:0][31:0] t_vec;

    // cubic Bezier control points of one segment
    typedef struct packed {
        t_vec p0;
        t_vec p1;
        t_vec p2;
        t_vec p3;
    } t_ctrl;

    typedef struct packed {
        logic full;
        logic not_empty;
    } t_q_stat;

endpackage

`default_nettype wire

>>> src/hcs_seg_if.sv
// ----------------------------------------------------------------------------
// hcs_seg_if
// Segment channel: end points and tangents, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface hcs_seg_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
    logic signed [31:0] start_tan_x;
    logic signed [31:0] start_tan_y;
    logic signed [31:0] start_tan_z;
    logic signed [31:0] end_tan_x;
    logic signed [31:0] end_tan_y;
    logic signed [31:0] end_tan_z;

    modport source (
        output valid, start_x, start_y, start_z, end_x, end_y, end_z,
               start_tan_x, start_tan_y, start_tan_z, end_tan_x, end_tan_y, end_tan_z,
        input  ready
    );
    modport sink (
        input  valid, start_x, start_y, start_z, end_x, end_y, end_z,
               start_tan_x, start_tan_y, start_tan_z, end_tan_x, end_tan_y, end_tan_z,
        output ready
    );
endinterface

`default_nettype wire

>>> src/hcs_pt_if.sv
// ----------------------------------------------------------------------------
// hcs_pt_if
// Point channel: one sampled curve point per beat, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface hcs_pt_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               last_point;

    modport source (output valid, point_x, point_y, point_z, last_point, input ready);
    modport sink   (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

`default_nettype wire

>>> src/hcs_front.sv
// ----------------------------------------------------------------------------
// hcs_front
// Takes a segment, forms the inner Bezier control points with a shared
// multiplier and a bit-serial divider, and pushes the control set on.
// ----------------------------------------------------------------------------
`default_nettype none

module hcs_front
    import hcs_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    hcs_seg_if.sink      i_seg,
    input  wire t_q_stat i_q_stat,
    output logic         o_q_push,
    output t_ctrl        o_q_data
);

    typedef enum logic [7:0] {
        F_IDLE   = 8'b0000_0001,
        F_MAC    = 8'b0000_0010,
        F_MUL_LO = 8'b0000_0100,
        F_MUL_HI = 8'b0000_1000,
        F_SETUP  = 8'b0001_0000,
        F_DIV    = 8'b0010_0000,
        F_FIN    = 8'b0100_0000,
        F_PUSH   = 8'b1000_0000
    } t_fstate;

    t_fstate           r_state;
    t_vec              r_a, r_b, r_ta, r_tb, r_p1, r_p2;
    logic [2:0][32:0]  r_d;
    logic [66:0]       r_lsq, r_dota, r_dotb;
    logic [3:0]        r_idx;
    logic              r_side;
    logic [1:0]        r_comp;
    logic [97:0]       r_num;
    logic [101:0]      r_rem, r_dv;
    logic [34:0]       r_quo;
    logic [5:0]        r_cnt;

    logic [1:0]         w_mcomp;
    logic signed [32:0] w_op1, w_op2;
    logic signed [65:0] w_prod;
    logic [66:0]        w_prod_ext;
    logic [66:0]        w_dot, w_mag;
    logic               w_dot_zero;
    logic [31:0]        w_tan, w_base, w_tmag;
    logic [32:0]        w_mul_op;
    logic [64:0]        w_mprod;
    logic [67:0]        w_den;
    logic [99:0]        w_numer;
    logic [33:0]        w_off;
    logic               w_neg;
    logic [35:0]        w_sum;
    logic [31:0]        w_inner;
    logic               w_last_comp;

    always_comb begin
        if (r_idx < 4'd3) begin
            w_mcomp = r_idx[1:0];
        end else if (r_idx < 4'd6) begin
            w_mcomp = 2'(r_idx - 4'd3);
        end else begin
            w_mcomp = 2'(r_idx - 4'd6);
        end
    end

    always_comb begin
        if (r_idx < 4'd3) begin
            w_op1 = r_d[w_mcomp];
        end else if (r_idx < 4'd6) begin
            w_op1 = {r_ta[w_mcomp][31], r_ta[w_mcomp]};
        end else begin
            w_op1 = {r_tb[w_mcomp][31], r_tb[w_mcomp]};
        end
    end

    assign w_op2      = r_d[w_mcomp];
    assign w_prod     = w_op1 * w_op2;
    assign w_prod_ext = {w_prod[65], w_prod};

    assign w_dot      = r_side ? r_dotb : r_dota;
    assign w_dot_zero = (w_dot == 67'd0);
    assign w_tan      = r_side ? r_tb[r_comp] : r_ta[r_comp];
    assign w_base     = r_side ? r_b[r_comp] : r_a[r_comp];
    assign w_tmag     = w_tan[31] ? (32'd0 - w_tan) : w_tan;

    // L is split in two halves so the product stays near 32 by 32
    assign w_mul_op   = (r_state == F_MUL_HI) ? r_lsq[65:33] : r_lsq[32:0];
    assign w_mprod    = {32'd0, w_mul_op} * {33'd0, w_tmag};

    assign w_mag      = w_dot[66] ? (67'd0 - w_dot) : w_dot;
    assign w_den      = {w_mag, 1'b0} + {1'b0, w_mag};
    assign w_numer    = {1'b0, r_num, 1'b0} + {32'd0, w_den};

    assign w_off   = (r_quo >= 35'h2_0000_0000) ? 34'h2_0000_0000 : r_quo[33:0];
    assign w_neg   = ((w_tan[31] != w_dot[66]) != r_side);
    assign w_sum   = {{4{w_base[31]}}, w_base}
                   + (w_neg ? (36'd0 - {2'd0, w_off}) : {2'd0, w_off});

    always_comb begin
        if (w_sum[35:31] == 5'b00000 || w_sum[35:31] == 5'b11111) begin
            w_inner = w_sum[31:0];
        end else if (w_sum[35]) begin
            w_inner = 32'h8000_0000;
        end else begin
            w_inner = 32'h7FFF_FFFF;
        end
    end

    assign w_last_comp = (r_comp == 2'd2) && r_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_seg.valid) begin
                        r_a    <= {i_seg.start_z, i_seg.start_y, i_seg.start_x};
                        r_b    <= {i_seg.end_z, i_seg.end_y, i_seg.end_x};
                        r_ta   <= {i_seg.start_tan_z, i_seg.start_tan_y, i_seg.start_tan_x};
                        r_tb   <= {i_seg.end_tan_z, i_seg.end_tan_y, i_seg.end_tan_x};
                        r_d[0] <= {i_seg.end_x[31], i_seg.end_x}
                                - {i_seg.start_x[31], i_seg.start_x};
                        r_d[1] <= {i_seg.end_y[31], i_seg.end_y}
                                - {i_seg.start_y[31], i_seg.start_y};
                        r_d[2] <= {i_seg.end_z[31], i_seg.end_z}
                                - {i_seg.start_z[31], i_seg.start_z};
                        r_lsq  <= '0;
                        r_dota <= '0;
                        r_dotb <= '0;
                        r_idx  <= '0;
                        r_state <= F_MAC;
                    end
                end
                F_MAC: begin
                    if (r_idx < 4'd3) begin
                        r_lsq <= r_lsq + w_prod_ext;
                    end else if (r_idx < 4'd6) begin
                        r_dota <= r_dota + w_prod_ext;
                    end else begin
                        r_dotb <= r_dotb + w_prod_ext;
                    end
                    r_idx <= r_idx + 4'd1;
                    if (r_idx == 4'd8) begin
                        r_side  <= 1'b0;
                        r_comp  <= 2'd0;
                        r_state <= F_MUL_LO;
                    end
                end
                F_MUL_LO: begin
                    if (w_dot_zero) begin
                        // flat tangent: the inner point sits on the endpoint
                        if (r_side) begin
                            r_p2[r_comp] <= w_base;
                        end else begin
                            r_p1[r_comp] <= w_base;
                        end
                        if (w_last_comp) begin
                            r_state <= F_PUSH;
                        end else if (r_comp == 2'd2) begin
                            r_side <= 1'b1;
                            r_comp <= 2'd0;
                        end else begin
                            r_comp <= r_comp + 2'd1;
                        end
                    end else begin
                        r_num   <= {33'd0, w_mprod};
                        r_state <= F_MUL_HI;
                    end
                end
                F_MUL_HI: begin
                    r_num   <= r_num + {w_mprod, 33'd0};
                    r_state <= F_SETUP;
                end
                F_SETUP: begin
                    r_rem   <= {2'd0, w_numer};
                    r_dv    <= {w_den[66:0], 1'b0, 34'd0};
                    r_quo   <= '0;
                    r_cnt   <= '0;
                    r_state <= F_DIV;
                end
                F_DIV: begin
                    if (r_rem >= r_dv) begin
                        r_rem <= r_rem - r_dv;
                        r_quo <= {r_quo[33:0], 1'b1};
                    end else begin
                        r_quo <= {r_quo[33:0], 1'b0};
                    end
                    r_dv  <= {1'b0, r_dv[101:1]};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd34) begin
                        r_state <= F_FIN;
                    end
                end
                F_FIN: begin
                    if (r_side) begin
                        r_p2[r_comp] <= w_inner;
                    end else begin
                        r_p1[r_comp] <= w_inner;
                    end
                    if (w_last_comp) begin
                        r_state <= F_PUSH;
                    end else begin
                        if (r_comp == 2'd2) begin
                            r_side <= 1'b1;
                            r_comp <= 2'd0;
                        end else begin
                            r_comp <= r_comp + 2'd1;
                        end
                        r_state <= F_MUL_LO;
                    end
                end
                F_PUSH: begin
                    if (!i_q_stat.full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

    assign i_seg.ready  = (r_state == F_IDLE);
    assign o_q_push     = (r_state == F_PUSH) && !i_q_stat.full;
    assign o_q_data.p0  = r_a;
    assign o_q_data.p1  = r_p1;
    assign o_q_data.p2  = r_p2;
    assign o_q_data.p3  = r_b;

endmodule

`default_nettype wire

>>> src/hcs_queue.sv
// ----------------------------------------------------------------------------
// hcs_queue
// Two-entry queue of control point sets between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module hcs_queue
    import hcs_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_ctrl i_data,
    input  wire logic  i_pop,
    output t_q_stat    o_stat,
    output t_ctrl      o_head
);

    `include "hermite_curve_sampler_assert.svh"

    t_ctrl      r_mem [HCS_Q_DEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_data;
                r_wp        <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    assign o_stat.full      = (r_cnt == 2'(HCS_Q_DEPTH));
    assign o_stat.not_empty = (r_cnt != 2'd0);
    assign o_head           = r_mem[r_rp];

    `HCS_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, i_push, r_cnt != 2'(HCS_Q_DEPTH), "push into full queue")
    `HCS_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, i_pop, r_cnt != 2'd0, "pop from empty queue")

endmodule

`default_nettype wire

>>> src/hcs_back.sv
// ----------------------------------------------------------------------------
// hcs_back
// Evaluates the cubic at t = k/(N+1) for each control set in the queue:
// Bernstein weights, three lanes of multiply-accumulate, bit-serial divide.
// ----------------------------------------------------------------------------
`default_nettype none

module hcs_back
    import hcs_pkg::*;
#(
    parameter int MAX_POINTS = HCS_MAX_POINTS
)(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [HCS_PC_W-1:0] i_point_count,
    input  wire t_q_stat             i_q_stat,
    input  wire t_ctrl               i_q_head,
    output logic                     o_q_pop,
    hcs_pt_if.source                 o_pt
);

    `include "hermite_curve_sampler_assert.svh"

    typedef enum logic [8:0] {
        B_IDLE = 9'b0_0000_0001,
        B_SQ   = 9'b0_0000_0010,
        B_CUBE = 9'b0_0000_0100,
        B_W1   = 9'b0_0000_1000,
        B_W2   = 9'b0_0001_0000,
        B_MAC  = 9'b0_0010_0000,
        B_PREP = 9'b0_0100_0000,
        B_DIV  = 9'b0_1000_0000,
        B_OUT  = 9'b1_0000_0000
    } t_bstate;

    t_bstate          r_state;
    logic [6:0]       r_n, r_m, r_k, r_u;
    logic [13:0]      r_m2, r_u2, r_k2;
    logic [18:0]      r_m3;
    logic [3:0][18:0] r_w;
    logic [1:0]       r_j;
    logic [2:0][51:0] r_s;
    logic [2:0][51:0] r_rem;
    logic [51:0]      r_dv;
    logic [2:0][31:0] r_quo;
    logic [4:0]       r_cnt;
    logic             r_ovalid;
    logic [2:0][31:0] r_out;
    logic             r_olast;

    logic [6:0]         w_n;
    logic [6:0]         w_u;
    logic [18:0]        w_ku2, w_k2u;
    t_vec               w_cpj;
    logic signed [51:0] w_bprod [3];
    logic signed [52:0] w_x [3];
    logic               w_oslot;
    logic               w_emit;

    always_comb begin
        if (i_point_count == '0) begin
            w_n = 7'd1;
        end else if (i_point_count > 7'(MAX_POINTS)) begin
            w_n = 7'(MAX_POINTS);
        end else begin
            w_n = i_point_count;
        end
    end

    assign w_u   = r_m - r_k;
    assign w_ku2 = {12'd0, r_k} * {5'd0, r_u2};
    assign w_k2u = {5'd0, r_k2} * {12'd0, r_u};

    always_comb begin
        case (r_j)
            2'd0:    w_cpj = i_q_head.p0;
            2'd1:    w_cpj = i_q_head.p1;
            2'd2:    w_cpj = i_q_head.p2;
            default: w_cpj = i_q_head.p3;
        endcase
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_bprod[c] = $signed({1'b0, r_w[r_j]}) * $signed(w_cpj[c]);
            // bias by (N+1)^3 * 2^32 so the floor divide runs on a positive value
            w_x[c] = $signed({r_s[c], 1'b0}) + $signed({34'd0, r_m3})
                   + $signed({2'd0, r_m3, 32'd0});
        end
    end

    assign w_oslot = !r_ovalid || o_pt.ready;
    assign w_emit  = (r_state == B_OUT) && w_oslot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (o_pt.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (i_q_stat.not_empty) begin
                        r_n     <= w_n;
                        r_m     <= w_n + 7'd1;
                        r_k     <= 7'd1;
                        r_state <= B_SQ;
                    end
                end
                B_SQ: begin
                    r_m2    <= {7'd0, r_m} * {7'd0, r_m};
                    r_state <= B_CUBE;
                end
                B_CUBE: begin
                    r_m3    <= {5'd0, r_m2} * {12'd0, r_m};
                    r_state <= B_W1;
                end
                B_W1: begin
                    r_u     <= w_u;
                    r_u2    <= {7'd0, w_u} * {7'd0, w_u};
                    r_k2    <= {7'd0, r_k} * {7'd0, r_k};
                    r_state <= B_W2;
                end
                B_W2: begin
                    r_w[0]  <= {5'd0, r_u2} * {12'd0, r_u};
                    r_w[1]  <= {w_ku2[17:0], 1'b0} + w_ku2;
                    r_w[2]  <= {w_k2u[17:0], 1'b0} + w_k2u;
                    r_w[3]  <= {5'd0, r_k2} * {12'd0, r_k};
                    r_s     <= '0;
                    r_j     <= 2'd0;
                    r_state <= B_MAC;
                end
                B_MAC: begin
                    for (int c = 0; c < 3; c++) begin
                        r_s[c] <= r_s[c] + w_bprod[c];
                    end
                    r_j <= r_j + 2'd1;
                    if (r_j == 2'd3) begin
                        r_state <= B_PREP;
                    end
                end
                B_PREP: begin
                    for (int c = 0; c < 3; c++) begin
                        r_rem[c] <= w_x[c][51:0];
                    end
                    r_dv    <= {1'b0, r_m3, 32'd0};
                    r_quo   <= '0;
                    r_cnt   <= '0;
                    r_state <= B_DIV;
                end
                B_DIV: begin
                    for (int c = 0; c < 3; c++) begin
                        if (r_rem[c] >= r_dv) begin
                            r_rem[c] <= r_rem[c] - r_dv;
                            r_quo[c] <= {r_quo[c][30:0], 1'b1};
                        end else begin
                            r_quo[c] <= {r_quo[c][30:0], 1'b0};
                        end
                    end
                    r_dv  <= {1'b0, r_dv[51:1]};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_state <= B_OUT;
                    end
                end
                B_OUT: begin
                    if (w_oslot) begin
                        // remove the bias of 2^31 again
                        for (int c = 0; c < 3; c++) begin
                            r_out[c] <= r_quo[c] ^ 32'h8000_0000;
                        end
                        r_olast  <= (r_k == r_n);
                        if (r_k == r_n) begin
                            r_state <= B_IDLE;
                        end else begin
                            r_k     <= r_k + 7'd1;
                            r_state <= B_W1;
                        end
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    assign o_q_pop         = w_emit && (r_k == r_n);
    assign o_pt.valid      = r_ovalid;
    assign o_pt.point_x    = r_out[0];
    assign o_pt.point_y    = r_out[1];
    assign o_pt.point_z    = r_out[2];
    assign o_pt.last_point = r_olast;

    `HCS_ASSERT_IMP(a_busy_has_set, i_clk, i_rst_n, r_state != B_IDLE, i_q_stat.not_empty, "back busy without a queued set")
    `HCS_ASSERT_IMP(a_k_in_range, i_clk, i_rst_n, r_state == B_OUT, r_k >= 7'd1 && r_k <= r_n, "point index out of range")

endmodule

`default_nettype wire

>>> src/hermite_curve_sampler.sv
// Front: a segment passes a shared multiplier and a 35-step divider per inner coordinate,
//   6 of them; the back then evaluates its N points one after another.
// Back: each point runs the 32-step per-point divider before the next one starts; the
//   front works on the next segment meanwhile, with a two-entry queue between them.
// Reset: synchronous, active low; clears control state and sets point_count to 16.
// ----------------------------------------------------------------------------
// hermite_curve_sampler
// Samples cubic segments given in Hermite form at equidistant parameter steps.
// ----------------------------------------------------------------------------
`default_nettype none

module hermite_curve_sampler
    import hcs_pkg::*;
#(
    parameter int MAX_POINTS = HCS_MAX_POINTS
)(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [HCS_PC_W-1:0] i_cfg_data,
    hcs_seg_if.sink                  i_seg,
    hcs_pt_if.source                 o_pt
);

    logic [HCS_PC_W-1:0] r_point_count;
    logic                w_push, w_pop;
    t_ctrl               w_push_data, w_head;
    t_q_stat             w_q_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= HCS_PC_RESET;
        end else if (i_cfg_we) begin
            r_point_count <= i_cfg_data;
        end
    end

    hcs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_seg    (i_seg),
        .i_q_stat (w_q_stat),
        .o_q_push (w_push),
        .o_q_data (w_push_data)
    );

    hcs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_stat  (w_q_stat),
        .o_head  (w_head)
    );

    hcs_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_point_count (r_point_count),
        .i_q_stat      (w_q_stat),
        .i_q_head      (w_head),
        .o_q_pop       (w_pop),
        .o_pt          (o_pt)
    );

endmodule

`default_nettype wire

>>> dv/tb_hermite_curve_sampler.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hermite_curve_sampler
// Drives Hermite segments into the sampler, predicts every Bezier point in
// wide integer arithmetic and checks the point stream beat by beat, across
// several point counts, random idling on both sides and a long output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_hermite_curve_sampler;
    import hcs_pkg::*;

    typedef struct packed {
        t_vec a;
        t_vec b;
        t_vec ta;
        t_vec tb;
    } t_seg;

    typedef struct packed {
        t_vec p;
        logic last;
    } t_point;

    logic                i_clk;
    logic                i_rst_n;
    logic                cfg_we;
    logic [HCS_PC_W-1:0] cfg_data;

    hcs_seg_if seg ();
    hcs_pt_if  pt ();

    hermite_curve_sampler i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_seg      (seg.sink),
        .o_pt       (pt.source)
    );

    t_seg   seg_pending[$];
    t_point points_due[$];
    int     n_fail;
    int     point_count_cur;
    bit     calm;
    bit     hold_req;
    bit     hold_done;
    int     hold_left;

    always #2 i_clk = ~i_clk;

    function automatic void add_seg(t_seg s);
        seg_pending = {seg_pending, s};
    endfunction

    function automatic longint sx(logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
        if (v < -64'sh8000_0000) return -64'sh8000_0000;
        return v;
    endfunction

    // base plus or minus tan * lsq / (3 * dot), rounded half away from zero
    function automatic longint inner_coord(longint base, longint tan_c, logic [127:0] lsq,
                                           logic signed [127:0] dot, bit far_end);
        logic [127:0] mag, num, den, q, tmag;
        longint       off;
        bit           dneg, neg;
        if (dot == 0) return base;
        dneg = dot[127];
        mag  = dneg ? -dot : dot;
        tmag = (tan_c < 0) ? 128'(-tan_c) : 128'(tan_c);
        num  = lsq * tmag;
        den  = mag * 3;
        q    = (2 * num + den) / (2 * den);
        off  = (q >= 128'h2_0000_0000) ? 64'sh2_0000_0000 : longint'(q[63:0]);
        neg  = ((tan_c < 0) != dneg) != far_end;
        return clamp32(neg ? base - off : base + off);
    endfunction

    function automatic void predict_points(t_seg s);
        longint              cp[4][3];
        longint              d[3], w[4], n, m, m3, sum, r, bias;
        logic [63:0]         ad, prod;
        logic [127:0]        lsq;
        logic signed [127:0] dot_a, dot_b;
        t_point              e;
        lsq   = 0;
        dot_a = 0;
        dot_b = 0;
        bias  = longint'(1) << 31;
        for (int c = 0; c < 3; c++) begin
            d[c]  = sx(s.b[c]) - sx(s.a[c]);
            ad    = (d[c] < 0) ? -d[c] : d[c];
            lsq   = lsq + {64'b0, ad * ad};
            prod  = sx(s.ta[c]) * d[c];
            dot_a = dot_a + {{64{prod[63]}}, prod};
            prod  = sx(s.tb[c]) * d[c];
            dot_b = dot_b + {{64{prod[63]}}, prod};
        end
        for (int c = 0; c < 3; c++) begin
            cp[0][c] = sx(s.a[c]);
            cp[1][c] = inner_coord(sx(s.a[c]), sx(s.ta[c]), lsq, dot_a, 1'b0);
            cp[2][c] = inner_coord(sx(s.b[c]), sx(s.tb[c]), lsq, dot_b, 1'b1);
            cp[3][c] = sx(s.b[c]);
        end
        n = point_count_cur;
        if (n < 1) n = 1;
        if (n > HCS_MAX_POINTS) n = HCS_MAX_POINTS;
        m  = n + 1;
        m3 = m * m * m;
        for (longint k = 1; k <= n; k++) begin
            w[0] = (m - k) * (m - k) * (m - k);
            w[1] = 3 * k * (m - k) * (m - k);
            w[2] = 3 * k * k * (m - k);
            w[3] = k * k * k;
            for (int c = 0; c < 3; c++) begin
                sum = w[0] * cp[0][c] + w[1] * cp[1][c] + w[2] * cp[2][c] + w[3] * cp[3][c];
                // shift positive so integer division floors, ties go up
                r = (2 * (sum + m3 * bias) + m3) / (2 * m3);
                e.p[c] = 32'(r - bias);
            end
            e.last = (k == n);
            points_due = {points_due, e};
        end
    endfunction

    function automatic logic [31:0] small_val(int span);
        return 32'($urandom_range(0, 2 * span) - span);
    endfunction

    // mostly well-formed curves, some raw noise across every bit
    function automatic t_seg make_seg();
        t_seg s;
        int   kind;
        kind = $urandom_range(0, 9);
        for (int c = 0; c < 3; c++) begin
            if (kind < 2) begin
                s.a[c] = $urandom; s.b[c] = $urandom; s.ta[c] = $urandom; s.tb[c] = $urandom;
            end else begin
                s.a[c] = small_val(1 << 22);
                s.b[c] = small_val(1 << 22);
                s.ta[c] = small_val(1 << 20);
                s.tb[c] = small_val(1 << 20);
            end
        end
        if (kind == 9) s.ta = '0;
        if (kind == 8) s.b = s.a;
        return s;
    endfunction

    function automatic t_seg seg_of(logic [31:0] a, logic [31:0] b,
                                    logic [31:0] ta, logic [31:0] tb);
        t_seg s;
        for (int c = 0; c < 3; c++) begin
            s.a[c] = a; s.b[c] = b; s.ta[c] = ta; s.tb[c] = tb;
        end
        return s;
    endfunction

    // driver: hold a beat until taken, then offer the next one
    always @(posedge i_clk) begin : seg_drive
        t_seg nxt;
        bit   gap;
        if (!i_rst_n) begin
            seg.valid <= 1'b0;
        end else begin
            if (seg.valid && seg.ready) begin
                predict_points({{seg.start_z, seg.start_y, seg.start_x},
                                {seg.end_z, seg.end_y, seg.end_x},
                                {seg.start_tan_z, seg.start_tan_y, seg.start_tan_x},
                                {seg.end_tan_z, seg.end_tan_y, seg.end_tan_x}});
            end
            if (!(seg.valid && !seg.ready)) begin
                gap = !calm && ($urandom_range(0, 99) < 10);
                if (seg_pending.size() > 0 && !gap) begin
                    nxt = seg_pending.pop_front();
                    seg.start_x <= nxt.a[0]; seg.start_y <= nxt.a[1]; seg.start_z <= nxt.a[2];
                    seg.end_x <= nxt.b[0]; seg.end_y <= nxt.b[1]; seg.end_z <= nxt.b[2];
                    seg.start_tan_x <= nxt.ta[0]; seg.start_tan_y <= nxt.ta[1];
                    seg.start_tan_z <= nxt.ta[2];
                    seg.end_tan_x <= nxt.tb[0]; seg.end_tan_y <= nxt.tb[1];
                    seg.end_tan_z <= nxt.tb[2];
                    seg.valid <= 1'b1;
                end else begin
                    seg.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : pt_check
        t_point e;
        bit     rdy;
        if (!i_rst_n) begin
            pt.ready <= 1'b0;
        end else begin
            if (pt.valid && pt.ready) begin
                if (points_due.size() == 0) begin
                    $error("point beat with nothing expected");
                    n_fail++;
                end else begin
                    e = points_due.pop_front();
                    if (pt.point_x !== e.p[0]) begin
                        $error("point_x exp %0d got %0d", signed'(e.p[0]), pt.point_x);
                        n_fail++;
                    end
                    if (pt.point_y !== e.p[1]) begin
                        $error("point_y exp %0d got %0d", signed'(e.p[1]), pt.point_y);
                        n_fail++;
                    end
                    if (pt.point_z !== e.p[2]) begin
                        $error("point_z exp %0d got %0d", signed'(e.p[2]), pt.point_z);
                        n_fail++;
                    end
                    if (pt.last_point !== e.last) begin
                        $error("last_point exp %0b got %0b", e.last, pt.last_point);
                        n_fail++;
                    end
                end
            end
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = 600;
            end
            if (hold_left > 0) begin
                rdy = 1'b0;
                hold_left--;
            end else begin
                rdy = calm || ($urandom_range(0, 99) >= 10);
            end
            pt.ready <= rdy;
        end
    end

    // sample between edges so the clocked processes have settled
    task automatic wait_idle();
        while (seg_pending.size() > 0 || seg.valid || points_due.size() > 0)
            @(negedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_count(int v);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= HCS_PC_W'(v);
        point_count_cur = v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_random(int count);
        @(negedge i_clk);
        repeat (count) add_seg(make_seg());
    endtask

    initial begin
        int counts[10] = '{1, 0, 2, 3, 64, 127, 5, 8, 4, 1};
        int sizes[10]  = '{22, 20, 22, 22, 3, 3, 22, 20, 22, 20};
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        seg.valid = 1'b0;
        {seg.start_x, seg.start_y, seg.start_z, seg.end_x, seg.end_y, seg.end_z} = '0;
        {seg.start_tan_x, seg.start_tan_y, seg.start_tan_z} = '0;
        {seg.end_tan_x, seg.end_tan_y, seg.end_tan_z} = '0;
        pt.ready = 1'b0;
        n_fail = 0;
        calm = 1'b0;
        hold_req = 1'b0;
        hold_done = 1'b0;
        hold_left = 0;
        point_count_cur = HCS_PC_RESET;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed segments at the reset point count
        @(negedge i_clk);
        add_seg(seg_of('0, '0, '0, '0));
        add_seg(seg_of(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        add_seg(seg_of(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        add_seg(seg_of(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
        add_seg(seg_of(32'h0001_0000, 32'h0001_0000, 32'h0003_0000, 32'h0004_0000));
        add_seg(seg_of(32'h0000_0000, 32'h0010_0000, 32'h0000_0000, 32'h0001_0000));
        add_seg(seg_of(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));
        add_seg(seg_of(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));
        add_seg(seg_of(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF));
        // tangent perpendicular to the chord: zero dot on both ends
        add_seg('{a: {32'd0, 32'd0, 32'd0}, b: {32'd0, 32'd0, 32'h0002_0000},
            ta: {32'd0, 32'h0005_0000, 32'd0}, tb: {32'h0007_0000, 32'd0, 32'd0}});
        // long chord, tiny dot: offset hits its cap
        add_seg('{a: {32'd0, 32'd0, 32'h8000_0000}, b: {32'd0, 32'd1, 32'h7FFF_FFFF},
            ta: {32'd0, 32'd1, 32'd0}, tb: {32'd0, 32'hFFFF_FFFF, 32'd0}});
        // end points near positive full scale, inner points stay inside the range
        add_seg('{a: {32'd0, 32'd0, 32'h7FFF_0000}, b: {32'd0, 32'd0, 32'h7FFF_FFFF},
            ta: {32'd0, 32'd0, 32'h0000_0001}, tb: {32'd0, 32'd0, 32'h8000_0000}});
        repeat (6) add_seg(make_seg());

        for (int ph = 0; ph < 10; ph++) begin
            write_count(counts[ph]);
            if (ph == 2) begin
                @(negedge i_clk);
                hold_req = 1'b1;
            end
            calm = (ph == 6);
            if (ph == 3) begin
                // pause the sender until the block has drained
                queue_random(sizes[ph] / 2);
                wait_idle();
                queue_random(sizes[ph] - sizes[ph] / 2);
            end else begin
                queue_random(sizes[ph]);
            end
        end
        wait_idle();
        calm = 1'b0;
        repeat (100) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+src
src/hcs_pkg.sv
src/hcs_seg_if.sv
src/hcs_pt_if.sv
src/hcs_front.sv
src/hcs_queue.sv
src/hcs_back.sv
src/hermite_curve_sampler.sv
dv/tb_hermite_curve_sampler.sv
